/* design/gtpc_pkg.sv */
// Package for the glyph-to-page-column transposer.
// Sizes, register indices and FSM states. No dependencies.
package gtpc_pkg;

  localparam int unsigned MaxWidth   = 32;                 // widest glyph, pixels
  localparam int unsigned MaxPages   = 4;                  // tallest glyph, 8-row pages
  localparam int unsigned MaxRows    = MaxPages * 8;
  localparam int unsigned MaxGroups  = (MaxWidth + 7) / 8; // byte columns per row
  localparam int unsigned StoreDepth = MaxGroups * MaxRows;

  localparam int unsigned AddrW  = $clog2(StoreDepth);
  localparam int unsigned CountW = AddrW + 1;
  localparam int unsigned RowW   = $clog2(MaxRows);
  localparam int unsigned GrpW   = (MaxGroups > 1) ? $clog2(MaxGroups) : 1;
  localparam int unsigned BprW   = GrpW + 1;

  localparam int unsigned WidthW   = 6;
  localparam int unsigned PagesW   = 3;
  localparam int unsigned ColW     = 5;
  localparam int unsigned PagesOutW = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 6;

  typedef enum logic [CfgIdxW-1:0] {
    RegGlyphWidth  = 3'd0,
    RegGlyphPages  = 3'd1,
    RegBitOrderRev = 3'd2,
    RegUnderline   = 3'd3,
    RegInvert      = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StDrain,
    StEmit
  } state_e;

endpackage

/* design/glyph_to_page_column_bitmap.sv */
// Glyph row-to-page-column transposer, top level.
// Depends on gtpc_pkg.
//
// Accepts one glyph byte per cycle (start high, busy low) in row order, MSB
// leftmost, ceil(width/8) bytes per row, and keeps them in a 128 x 8 store.
// The byte that completes the glyph (ceil(width/8) * pages * 8 bytes) makes
// the block go busy and emit one word per pixel column, column 0 first,
// each shown for exactly one cycle on result_valid_o; the receiver cannot
// stall, so it must take every word as it appears. Columns are produced in
// groups of eight: the store's single read port fetches the group's byte of
// every row, a drain state lets the read pipe empty, then up to eight
// column words follow, one a cycle. Each word leaves through an output
// register in the cycle after its emit cycle, so the last word shows in the
// first idle cycle. No clearing pass after reset. Configuration is taken
// only while idle (cfg_ready_o).
module glyph_to_page_column_bitmap
  import gtpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // byte input
  input  logic                 start,
  output logic                 busy,
  input  logic [7:0]           glyph_byte_i,
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  // column words
  output logic                 result_valid_o,
  output logic [ColW-1:0]      column_index_o,
  output logic [PagesOutW-1:0] column_pages_o,
  output logic                 last_column_o
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WidthW-1:0] cfg_width_q;
  logic [PagesW-1:0] cfg_pages_q;
  logic              cfg_rev_q;
  logic              cfg_uline_q;
  logic              cfg_inv_q;
  logic              cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q <= WidthW'(16);
      cfg_pages_q <= PagesW'(2);
      cfg_rev_q   <= 1'b0;
      cfg_uline_q <= 1'b0;
      cfg_inv_q   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        RegGlyphWidth:  cfg_width_q <= cfg_data_i[WidthW-1:0];
        RegGlyphPages:  cfg_pages_q <= cfg_data_i[PagesW-1:0];
        RegBitOrderRev: cfg_rev_q   <= cfg_data_i[0];
        RegUnderline:   cfg_uline_q <= cfg_data_i[0];
        RegInvert:      cfg_inv_q   <= cfg_data_i[0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // Clamped geometry
  logic [WidthW-1:0]    w_eff;
  logic [PagesW-1:0]    pages_eff;
  logic [BprW-1:0]      bpr;
  logic [5:0]           bp_prod;
  logic [CountW-1:0]    total;
  logic [RowW:0]        nrows;

  always_comb begin
    w_eff = cfg_width_q;
    if (cfg_width_q == '0) w_eff = WidthW'(1);
    else if (cfg_width_q > WidthW'(MaxWidth)) w_eff = WidthW'(MaxWidth);
    pages_eff = cfg_pages_q;
    if (cfg_pages_q == '0) pages_eff = PagesW'(1);
    else if (cfg_pages_q > PagesW'(MaxPages)) pages_eff = PagesW'(MaxPages);
  end

  assign bpr     = BprW'((7'(w_eff) + 7'd7) >> 3);
  assign bp_prod = 6'(bpr) * 6'(pages_eff);
  assign total   = CountW'({bp_prod, 3'b000});
  assign nrows   = (RowW+1)'({pages_eff, 3'b000});

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_e             state_q, state_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0]   rd_addr_q;
  logic [RowW-1:0]    rd_row_q;
  logic [GrpW-1:0]    grp_q;
  logic [2:0]         col_q;
  logic               rd_vld_q;
  logic [RowW-1:0]    cap_row_q;
  logic [7:0]         rd_data_q;

  logic               byte_acc;
  logic [CountW-1:0]  cnt_inc;
  logic               glyph_done;
  logic [ColW-1:0]    x_cur;
  logic               last_row;
  logic               last_x;
  logic               last_in_grp;

  assign byte_acc   = start && !busy;
  assign cnt_inc    = cnt_q + CountW'(1);
  assign glyph_done = (cnt_inc >= total);
  assign x_cur      = ColW'({grp_q, col_q});
  assign last_row   = ({1'b0, rd_row_q} == nrows - (RowW+1)'(1));
  assign last_x     = (WidthW'(x_cur) == w_eff - WidthW'(1));
  assign last_in_grp = last_x || (col_q == 3'd7);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (byte_acc && glyph_done) state_d = StRead;
      StRead:  if (last_row) state_d = StDrain;
      StDrain: state_d = StEmit;
      StEmit:  if (last_in_grp) state_d = last_x ? StIdle : StRead;
      default: state_d = StIdle;
    endcase
  end

  // outputs of the FSM
  always_comb begin
    busy        = (state_q != StIdle);
    cfg_ready_o = (state_q == StIdle);
    cnt_d       = cnt_q;
    if (byte_acc) cnt_d = glyph_done ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      rd_addr_q <= '0;
      rd_row_q  <= '0;
      grp_q     <= '0;
      col_q     <= '0;
      rd_vld_q  <= 1'b0;
      cap_row_q <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      rd_vld_q  <= (state_q == StRead);
      cap_row_q <= rd_row_q;
      unique case (state_q)
        StIdle: begin
          rd_addr_q <= '0;
          rd_row_q  <= '0;
          grp_q     <= '0;
          col_q     <= '0;
        end
        StRead: begin
          rd_addr_q <= rd_addr_q + AddrW'(bpr);
          rd_row_q  <= rd_row_q + RowW'(1);
        end
        StDrain: col_q <= '0;
        StEmit: begin
          col_q <= col_q + 3'd1;
          if (last_in_grp) begin
            grp_q     <= grp_q + GrpW'(1);
            rd_addr_q <= AddrW'(grp_q) + AddrW'(1);
            rd_row_q  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Glyph store: one write port (loading), one registered read port
  // ---------------------------------------------------------------------------
  logic [7:0] store_mem [StoreDepth];

  always_ff @(posedge clk_i) begin
    if (byte_acc && !cnt_q[CountW-1]) begin
      store_mem[cnt_q[AddrW-1:0]] <= glyph_byte_i;
    end
    if (state_q == StRead) begin
      rd_data_q <= store_mem[rd_addr_q];
    end
  end

  // Row buffer: the current group's byte of every row
  logic [7:0] rowbuf_q [MaxRows];

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) rowbuf_q[cap_row_q] <= rd_data_q;
  end

  // ---------------------------------------------------------------------------
  // Column assembly
  // ---------------------------------------------------------------------------
  logic [PagesOutW-1:0] pages_word;

  always_comb begin
    logic [7:0] pb;
    logic       pix;
    pages_word = '0;
    for (int p = 0; p < MaxPages; p++) begin
      pb = '0;
      for (int r = 0; r < 8; r++) begin
        pix = rowbuf_q[p*8 + r][3'd7 - col_q];
        if (cfg_rev_q) pb[r] = pix;
        else           pb[7-r] = pix;
      end
      if (cfg_uline_q && (PagesW'(p + 1) == pages_eff)) pb[7] = 1'b1;
      if (cfg_inv_q) pb = ~pb;
      if (PagesW'(p) < pages_eff) pages_word[p*8 +: 8] = pb;
    end
  end

  logic                 res_vld_q;
  logic [ColW-1:0]      res_idx_q;
  logic [PagesOutW-1:0] res_pages_q;
  logic                 res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= (state_q == StEmit);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StEmit) begin
      res_idx_q   <= x_cur;
      res_pages_q <= pages_word;
      res_last_q  <= last_x;
    end
  end

  assign result_valid_o = res_vld_q;
  assign column_index_o = res_idx_q;
  assign column_pages_o = res_pages_q;
  assign last_column_o  = res_last_q;

`ifndef SYNTHESIS
  // a word only follows an emit cycle
  a_word_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == StEmit))
    else $error("column word without emit cycle");

  // the final column ends the burst
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_column_o |=> !result_valid_o && !busy)
    else $error("words continue after last column");

  // byte count always addresses the store
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cnt_q[CountW-1])
    else $error("byte count beyond store depth");

  // going busy only on the byte that completes a glyph
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && glyph_done))
    else $error("busy without completed glyph");
`endif

endmodule
